FILE: rtl/brle_pkg.sv
package brle_pkg;

    // Input beat: one packed byte with its end-of-stream flag
    typedef struct packed {
        logic [7:0] packed_byte;
        logic       stream_end;
    } byte_beat_t;

    // Output beat: byte-lane word with lane count and status
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic [1:0]  status;
        logic        last_of_run;
        logic        output_end;
    } word_beat_t;

    // Status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_MISSING_RUN = 2'd1;
    localparam logic [1:0] STATUS_TRUNC_LIT   = 2'd2;

    // Header decode
    localparam logic [7:0] RUN_FLAG  = 8'h80;
    localparam logic [7:0] LEN_MASK  = 8'h7F;
    localparam logic [7:0] RUN_BIAS  = 8'd3;

    // Word geometry
    localparam int MAX_LANES = 8;
    localparam int WORD_W    = 64;

    // Controller states
    typedef enum logic [1:0] {
        ST_HEADER,
        ST_RUN_VALUE,
        ST_LITERAL,
        ST_RUN_EMIT
    } brle_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_header;
        logic take_literal;
        logic take_run_value;
        logic emit_run;
        logic emit_error;
    } brle_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic run_fits;
        logic lit_last;
    } brle_sts_t;

endpackage

FILE: rtl/brle_ctrl.sv
module brle_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  brle_pkg::byte_beat_t   byte_beat,
    input  brle_pkg::brle_sts_t    sts,
    output logic                   byte_stall,
    output brle_pkg::brle_cmd_t    cmd
);

    brle_pkg::brle_state_t state_reg;
    brle_pkg::brle_state_t state_next;
    logic                  accept;
    logic                  hdr_is_run;

    assign hdr_is_run = (byte_beat.packed_byte & brle_pkg::RUN_FLAG) != 8'd0;

    // Input is held while a run drains or the output register is full and stalled
    assign byte_stall = (state_reg == brle_pkg::ST_RUN_EMIT) || !sts.out_free;
    assign accept     = byte_valid && !byte_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brle_pkg::ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brle_pkg::ST_HEADER:
            begin
                if (accept && !byte_beat.stream_end)
                begin
                    state_next = hdr_is_run ? brle_pkg::ST_RUN_VALUE : brle_pkg::ST_LITERAL;
                end
            end
            brle_pkg::ST_LITERAL:
            begin
                if (accept && (byte_beat.stream_end || sts.lit_last))
                begin
                    state_next = brle_pkg::ST_HEADER;
                end
            end
            brle_pkg::ST_RUN_VALUE:
            begin
                if (accept)
                begin
                    state_next = sts.run_fits ? brle_pkg::ST_HEADER : brle_pkg::ST_RUN_EMIT;
                end
            end
            brle_pkg::ST_RUN_EMIT:
            begin
                if (sts.out_free && sts.run_fits)
                begin
                    state_next = brle_pkg::ST_HEADER;
                end
            end
            default:
            begin
                state_next = brle_pkg::ST_HEADER;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            brle_pkg::ST_HEADER:
            begin
                cmd.take_header = accept && !byte_beat.stream_end;
                cmd.emit_error  = accept && byte_beat.stream_end;
            end
            brle_pkg::ST_LITERAL:
            begin
                cmd.take_literal = accept;
            end
            brle_pkg::ST_RUN_VALUE:
            begin
                cmd.take_run_value = accept;
            end
            brle_pkg::ST_RUN_EMIT:
            begin
                cmd.emit_run = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/brle_datapath.sv
module brle_datapath #(
    parameter int LANES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  brle_pkg::byte_beat_t   byte_beat,
    input  brle_pkg::brle_cmd_t    cmd,
    input  logic                   word_stall,
    output brle_pkg::brle_sts_t    sts,
    output logic                   word_valid,
    output brle_pkg::word_beat_t   word_beat
);

    // Lane count clamped to the supported range
    localparam int LANE_N = (LANES < 4) ? 4 :
                            ((LANES > brle_pkg::MAX_LANES) ? brle_pkg::MAX_LANES : LANES);

    logic [7:0]           run_left_reg;
    logic [7:0]           run_left_next;
    logic [7:0]           lit_left_reg;
    logic [7:0]           lit_left_next;
    logic [7:0]           value_reg;
    logic                 end_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    brle_pkg::word_beat_t out_reg;
    brle_pkg::word_beat_t out_next;

    logic       load;
    logic [3:0] run_n;
    logic [7:0] run_byte;
    logic       run_end;
    logic [63:0] run_word;

    assign load = cmd.take_literal || cmd.take_run_value || cmd.emit_run || cmd.emit_error;

    // Status back to the controller
    assign sts.out_free = !out_valid_reg || !word_stall;
    assign sts.run_fits = run_left_reg <= 8'(LANE_N);
    assign sts.lit_last = lit_left_reg == 8'd1;

    // Run word: source byte is the input on the first word, latched after
    assign run_byte = cmd.take_run_value ? byte_beat.packed_byte : value_reg;
    assign run_end  = cmd.take_run_value ? byte_beat.stream_end : end_reg;
    assign run_n    = sts.run_fits ? run_left_reg[3:0] : 4'(LANE_N);

    always_comb
    begin
        run_word = '0;
        for (int i = 0; i < brle_pkg::MAX_LANES; i++)
        begin
            if (4'(i) < run_n)
            begin
                run_word[i*8 +: 8] = run_byte;
            end
        end
    end

    // Counter updates
    always_comb
    begin
        run_left_next = run_left_reg;
        lit_left_next = lit_left_reg;
        if (cmd.take_header)
        begin
            run_left_next = (byte_beat.packed_byte & brle_pkg::LEN_MASK) + brle_pkg::RUN_BIAS;
            lit_left_next = byte_beat.packed_byte + 8'd1;
        end
        if (cmd.take_run_value || cmd.emit_run)
        begin
            run_left_next = run_left_reg - {4'd0, run_n};
        end
        if (cmd.take_literal)
        begin
            lit_left_next = lit_left_reg - 8'd1;
        end
    end

    // Next output beat
    always_comb
    begin
        out_next = out_reg;
        priority if (cmd.emit_error)
        begin
            out_next.data_word   = '0;
            out_next.byte_count  = 4'd0;
            out_next.status      = ((byte_beat.packed_byte & brle_pkg::RUN_FLAG) != 8'd0)
                                   ? brle_pkg::STATUS_MISSING_RUN : brle_pkg::STATUS_TRUNC_LIT;
            out_next.last_of_run = 1'b1;
            out_next.output_end  = 1'b1;
        end
        else if (cmd.take_literal)
        begin
            out_next.data_word   = {56'd0, byte_beat.packed_byte};
            out_next.byte_count  = 4'd1;
            out_next.status      = (byte_beat.stream_end && !sts.lit_last)
                                   ? brle_pkg::STATUS_TRUNC_LIT : brle_pkg::STATUS_OK;
            out_next.last_of_run = 1'b1;
            out_next.output_end  = byte_beat.stream_end;
        end
        else if (cmd.take_run_value || cmd.emit_run)
        begin
            out_next.data_word   = run_word;
            out_next.byte_count  = run_n;
            out_next.status      = brle_pkg::STATUS_OK;
            out_next.last_of_run = sts.run_fits;
            out_next.output_end  = sts.run_fits && run_end;
        end
        else
        begin
            out_next = out_reg;
        end
    end

    assign out_valid_next = load ? 1'b1 : (out_valid_reg && word_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            run_left_reg  <= 8'd0;
            lit_left_reg  <= 8'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            run_left_reg  <= run_left_next;
            lit_left_reg  <= lit_left_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
        if (cmd.take_run_value)
        begin
            value_reg <= byte_beat.packed_byte;
            end_reg   <= byte_beat.stream_end;
        end
    end

    assign word_valid = out_valid_reg;
    assign word_beat  = out_reg;

endmodule

FILE: rtl/byte_rle_decoder_unit.sv
// Packbits-style run-length decoder. One packed byte per input beat; a set
// stream_end marks the final byte. A header with bit 7 set repeats the next
// byte (low 7 bits + 3) times, emitted as words of up to LANES bytes (LANES
// clamped to 4..8; lane 0 in the low bits, unused lanes zero). A header with
// bit 7 clear passes the next (header + 1) bytes through, one single-byte
// word each. A stream that ends on a header gives one empty word with status
// 1 (run) or 2 (literal); a literal cut short by stream_end carries status 2
// on its last byte, and earlier bytes stay delivered. Headers and literal
// bytes are taken whenever byte_stall is low. After a run value byte,
// byte_stall stays high while the rest of the run goes out as words through
// the single output register. Output stall backs up into byte_stall only
// when the output register is still full.
module byte_rle_decoder_unit #(
    parameter int LANES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  brle_pkg::byte_beat_t  byte_beat,
    output logic                  word_valid,
    input  logic                  word_stall,
    output brle_pkg::word_beat_t  word_beat
);

    brle_pkg::brle_cmd_t cmd;
    brle_pkg::brle_sts_t sts;

    // Sequencer
    brle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_beat  (byte_beat),
        .sts        (sts),
        .byte_stall (byte_stall),
        .cmd        (cmd)
    );

    // Counters, word build and output register
    brle_datapath #(
        .LANES (LANES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_beat  (byte_beat),
        .cmd        (cmd),
        .word_stall (word_stall),
        .sts        (sts),
        .word_valid (word_valid),
        .word_beat  (word_beat)
    );

endmodule
